// ===== src/vht_pkg.sv =====
// Shared types and constants of the voxel hysteresis threshold block.
// Used by vht_seq and voxel_hysteresis_threshold; depends on nothing.
package vht_pkg;

	// Item actions
	localparam logic ACT_WRITE    = 1'b0;
	localparam logic ACT_CLASSIFY = 1'b1;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_LOW_THRESHOLD = 3'd0,
		REG_RIM_THRESHOLD = 3'd1,
		REG_MODE_3D       = 3'd2,
		REG_SIZE_X        = 3'd3,
		REG_SIZE_Y        = 3'd4,
		REG_SIZE_Z        = 3'd5
	} cfg_reg_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned THRESH_W    = 16;
	localparam int unsigned SIZE_W      = 7;
	localparam int unsigned COORD_W     = 6;
	localparam int unsigned INSAMPLE_W  = 16;
	// window coordinate: coordinate plus offset, wraps to all ones below zero
	localparam int unsigned WIN_W       = 8;

	// Reset values: 117.6 and 235.3 in unsigned 10.6, truncated
	localparam logic [THRESH_W-1:0] LOW_RESET    = 16'd7526;
	localparam logic [THRESH_W-1:0] BORDER_RESET = 16'd15059;
	localparam logic [SIZE_W-1:0]   SIZE_RESET   = 7'd64;

	typedef struct packed {
		logic [THRESH_W-1:0] low_threshold;
		logic [THRESH_W-1:0] rim_threshold;
		logic                mode_3d;
		logic [SIZE_W-1:0]   size_x;
		logic [SIZE_W-1:0]   size_y;
		logic [SIZE_W-1:0]   size_z;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic               crack;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTRE,
		ST_WIN,
		ST_DRAIN,
		ST_DONE
	} seq_state_t;

endpackage

// ===== src/voxel_hysteresis_threshold.sv =====
// Voxel hysteresis threshold: top level with configuration and result registers.
// Depends on vht_pkg, vht_store and vht_seq.
// A write is stored at its accept edge. A classify decided by its centre voxel goes from the
// centre read straight to the result; a window search reads one window voxel per cycle from the
// single-port store. Writes are accepted one per cycle while idle; no new request is taken until
// a classify has passed its result on. Reset restores control and configuration registers only.
module voxel_hysteresis_threshold #(
	parameter int unsigned MAX_X       = 64,
	parameter int unsigned MAX_Y       = 64,
	parameter int unsigned MAX_Z       = 64,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [vht_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [vht_pkg::CFG_DATA_W-1:0]      cfg_data,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic [vht_pkg::COORD_W-1:0]         pos_x,
	input  logic [vht_pkg::COORD_W-1:0]         pos_y,
	input  logic [vht_pkg::COORD_W-1:0]         pos_z,
	input  logic [vht_pkg::INSAMPLE_W-1:0]      sample,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                crack,
	output logic [vht_pkg::COORD_W-1:0]         out_x,
	output logic [vht_pkg::COORD_W-1:0]         out_y,
	output logic [vht_pkg::COORD_W-1:0]         out_z
);

	// Store address is the concatenation {z, y, x}, each axis padded to a power of two.
	localparam int unsigned XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
	localparam int unsigned YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
	localparam int unsigned ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
	localparam int unsigned AW = XW + YW + ZW;

	vht_pkg::cfg_t    cfg_q;
	vht_pkg::result_t res;
	logic             res_ready;

	logic                         mem_en, mem_we;
	logic [AW-1:0]                mem_addr;
	logic [SAMPLE_BITS-1:0]       mem_wdata, mem_rdata;

	logic                         out_valid_q, crack_q;
	logic [vht_pkg::COORD_W-1:0]  out_x_q, out_y_q, out_z_q;

	// Configuration: always ready, writes beyond the register list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_threshold <= vht_pkg::LOW_RESET;
			cfg_q.rim_threshold <= vht_pkg::BORDER_RESET;
			cfg_q.mode_3d       <= 1'b1;
			cfg_q.size_x        <= vht_pkg::SIZE_RESET;
			cfg_q.size_y        <= vht_pkg::SIZE_RESET;
			cfg_q.size_z        <= vht_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (vht_pkg::cfg_reg_t'(cfg_index))
				vht_pkg::REG_LOW_THRESHOLD: cfg_q.low_threshold <= cfg_data;
				vht_pkg::REG_RIM_THRESHOLD: cfg_q.rim_threshold <= cfg_data;
				vht_pkg::REG_MODE_3D:       cfg_q.mode_3d       <= cfg_data[0];
				vht_pkg::REG_SIZE_X:
					cfg_q.size_x <= cfg_data[vht_pkg::SIZE_W-1:0];
				vht_pkg::REG_SIZE_Y:
					cfg_q.size_y <= cfg_data[vht_pkg::SIZE_W-1:0];
				vht_pkg::REG_SIZE_Z:
					cfg_q.size_z <= cfg_data[vht_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	vht_store #(
		.AW (AW),
		.DW (SAMPLE_BITS)
	) u_store (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	vht_seq #(
		.MAX_X       (MAX_X),
		.MAX_Y       (MAX_Y),
		.MAX_Z       (MAX_Z),
		.SAMPLE_BITS (SAMPLE_BITS),
		.XW          (XW),
		.YW          (YW),
		.ZW          (ZW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.sample    (sample),
		.mem_en    (mem_en),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.res       (res),
		.res_ready (res_ready)
	);

	// Result register: load when empty or being drained this cycle, so the
	// sequencer can return to idle while a result still waits downstream.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			crack_q <= res.crack;
			out_x_q <= res.x;
			out_y_q <= res.y;
			out_z_q <= res.z;
		end
	end

	assign out_valid = out_valid_q;
	assign crack     = crack_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;

endmodule

// ===== src/vht_store.sv =====
// Single-port voxel memory with a registered read port.
// Standalone; no package dependency.
module vht_store #(
	parameter int unsigned AW = 18,
	parameter int unsigned DW = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/vht_seq.sv =====
// Request sequencer: stores samples, reads the centre voxel and, when it lies between
// the thresholds, walks the window one voxel per cycle against the store. Depends on vht_pkg.
module vht_seq #(
	parameter int unsigned MAX_X       = 64,
	parameter int unsigned MAX_Y       = 64,
	parameter int unsigned MAX_Z       = 64,
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned XW          = 6,
	parameter int unsigned YW          = 6,
	parameter int unsigned ZW          = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  vht_pkg::cfg_t                      cfg,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               action,
	input  logic [vht_pkg::COORD_W-1:0]        pos_x,
	input  logic [vht_pkg::COORD_W-1:0]        pos_y,
	input  logic [vht_pkg::COORD_W-1:0]        pos_z,
	input  logic [vht_pkg::INSAMPLE_W-1:0]     sample,
	output logic                               mem_en,
	output logic                               mem_we,
	output logic [XW+YW+ZW-1:0]                mem_addr,
	output logic [SAMPLE_BITS-1:0]             mem_wdata,
	input  logic [SAMPLE_BITS-1:0]             mem_rdata,
	output vht_pkg::result_t                   res,
	input  logic                               res_ready
);

	localparam int unsigned CMP_W =
		(SAMPLE_BITS > vht_pkg::THRESH_W) ? SAMPLE_BITS : vht_pkg::THRESH_W;

	function automatic logic [vht_pkg::WIN_W-1:0] win_pos(
		input logic [vht_pkg::COORD_W-1:0] p,
		input logic [1:0]                  d
	);
		return vht_pkg::WIN_W'(p) + vht_pkg::WIN_W'(d) - vht_pkg::WIN_W'(1);
	endfunction

	// strictly inside the borders: 1 <= p and p + 1 < extent
	function automatic logic is_inner(
		input logic [vht_pkg::WIN_W-1:0]  p,
		input logic [vht_pkg::SIZE_W-1:0] ext
	);
		return (p != '0) &&
			(((vht_pkg::WIN_W+1)'(p) + (vht_pkg::WIN_W+1)'(1)) < (vht_pkg::WIN_W+1)'(ext));
	endfunction

	function automatic logic [vht_pkg::SIZE_W-1:0] clamp_ext(
		input logic [vht_pkg::SIZE_W-1:0] s,
		input int unsigned                lim
	);
		return (32'(s) > lim) ? vht_pkg::SIZE_W'(lim) : s;
	endfunction

	vht_pkg::seq_state_t state_q, state_d;

	logic [vht_pkg::COORD_W-1:0] x_q, y_q, z_q;
	logic                        cin_q, cin_d;
	logic [1:0]                  dx_q, dy_q, dz_q, dx_d, dy_d, dz_d;
	logic                        pend_q, pend_d;
	logic                        crack_q, crack_d;
	logic                        take;

	logic [vht_pkg::SIZE_W-1:0] ext_x, ext_y, ext_z;
	logic [vht_pkg::WIN_W-1:0]  wx, wy, wz;
	logic                       win_ok, win_last, in_store;
	logic [CMP_W-1:0]           centre, rd_ext, low_ext, rim_ext;

	assign ext_x = clamp_ext(cfg.size_x, MAX_X);
	assign ext_y = clamp_ext(cfg.size_y, MAX_Y);
	assign ext_z = clamp_ext(cfg.size_z, MAX_Z);

	assign wx = win_pos(x_q, dx_q);
	assign wy = win_pos(y_q, dy_q);
	assign wz = win_pos(z_q, dz_q);
	assign win_ok = is_inner(wx, ext_x) && is_inner(wy, ext_y) && is_inner(wz, ext_z);
	assign win_last = (dy_q == 2'd2) && (dx_q == 2'd2) && ((dz_q == 2'd2) || !cfg.mode_3d);

	assign in_store = (32'(pos_x) < MAX_X) && (32'(pos_y) < MAX_Y) && (32'(pos_z) < MAX_Z);

	assign rd_ext  = CMP_W'(mem_rdata);
	assign centre  = cin_q ? rd_ext : '0;
	assign low_ext = CMP_W'(cfg.low_threshold);
	assign rim_ext = CMP_W'(cfg.rim_threshold);

	always_comb begin
		state_d   = state_q;
		cin_d     = cin_q;
		dx_d      = dx_q;
		dy_d      = dy_q;
		dz_d      = dz_q;
		pend_d    = 1'b0;
		crack_d   = crack_q;
		take      = 1'b0;
		in_stall  = 1'b1;
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = {ZW'(pos_z), YW'(pos_y), XW'(pos_x)};
		mem_wdata = SAMPLE_BITS'(sample);
		res.valid = 1'b0;
		res.crack = crack_q;
		res.x     = x_q;
		res.y     = y_q;
		res.z     = z_q;
		case (state_q)
			vht_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					// write: store at once; classify: issue the centre read now
					mem_en = in_store;
					if (action == vht_pkg::ACT_WRITE) begin
						mem_we = 1'b1;
					end else begin
						take    = 1'b1;
						cin_d   = in_store;
						state_d = vht_pkg::ST_CENTRE;
					end
				end
			end
			vht_pkg::ST_CENTRE: begin
				dx_d = 2'd0;
				dy_d = 2'd0;
				dz_d = cfg.mode_3d ? 2'd0 : 2'd1;
				if (centre < low_ext) begin
					crack_d = 1'b1;
					state_d = vht_pkg::ST_DONE;
				end else if (centre <= rim_ext) begin
					state_d = vht_pkg::ST_WIN;
				end else begin
					crack_d = 1'b0;
					state_d = vht_pkg::ST_DONE;
				end
			end
			vht_pkg::ST_WIN: begin
				mem_addr = {ZW'(wz), YW'(wy), XW'(wx)};
				mem_en   = win_ok;
				pend_d   = win_ok;
				if (pend_q && (rd_ext < low_ext)) begin
					crack_d = 1'b1;
					state_d = vht_pkg::ST_DONE;
				end else if (win_last) begin
					state_d = vht_pkg::ST_DRAIN;
				end else if (dy_q != 2'd2) begin
					dy_d = dy_q + 2'd1;
				end else if (dx_q != 2'd2) begin
					dy_d = 2'd0;
					dx_d = dx_q + 2'd1;
				end else begin
					dy_d = 2'd0;
					dx_d = 2'd0;
					dz_d = dz_q + 2'd1;
				end
			end
			vht_pkg::ST_DRAIN: begin
				crack_d = pend_q && (rd_ext < low_ext);
				state_d = vht_pkg::ST_DONE;
			end
			vht_pkg::ST_DONE: begin
				res.valid = 1'b1;
				if (res_ready) begin
					state_d = vht_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vht_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vht_pkg::ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_q <= pos_x;
			y_q <= pos_y;
			z_q <= pos_z;
		end
		cin_q   <= cin_d;
		dx_q    <= dx_d;
		dy_q    <= dy_d;
		dz_q    <= dz_d;
		crack_q <= crack_d;
	end

endmodule
